@@ rtl/itoa_pkg.sv @@
// Shared types, constants and helper functions of the radix ASCII converter.
`default_nettype none

package itoa_pkg;

    localparam int NUM_W     = 32;
    localparam int BASE_W    = 6;
    localparam int CHAR_W    = 8;
    localparam int DIGIT_MAX = 32;                 // radix 2, top bit set
    localparam int IDX_W     = $clog2(DIGIT_MAX);
    localparam int BYTE_W    = 8;
    localparam int CHUNK_W   = $clog2(NUM_W / BYTE_W);

    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    localparam logic [BASE_W-1:0] BASE_MIN = 6'd2;
    localparam logic [BASE_W-1:0] BASE_MAX = 6'd36;
    localparam logic [BASE_W-1:0] BASE_DEC = 6'd10;

    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_A     = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_Z     = 8'h5A;

    // One classified conversion job, passed from front to back.
    typedef struct packed {
        logic [NUM_W-1:0]  mag;
        logic [BASE_W-1:0] radix;
        logic              negative;
        logic              bad;
    } job_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SIGN,
        ST_DIGITS,
        ST_ERR
    } back_state_t;

    // Digit value 0..35 to its ASCII code.
    function automatic logic [CHAR_W-1:0] digit_char(input logic [BASE_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        dx = {{(CHAR_W-BASE_W){1'b0}}, d};
        if (d < BASE_DEC)
            return CHAR_ZERO + dx;
        else
            return CHAR_A + dx - {{(CHAR_W-BASE_W){1'b0}}, BASE_DEC};
    endfunction

    // Index of the most significant nonzero byte; 0 for a zero word.
    function automatic logic [CHUNK_W-1:0] top_byte(input logic [NUM_W-1:0] v);
        logic [CHUNK_W-1:0] idx;
        idx = '0;
        for (int i = 1; i < NUM_W / BYTE_W; i++) begin
            if (v[i*BYTE_W +: BYTE_W] != '0)
                idx = CHUNK_W'(i);
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

@@ rtl/itoa_if.sv @@
// Stream interfaces for the number input and the character output channels.
`default_nettype none

interface itoa_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] number;
    logic        [5:0]  base;

    modport source (output valid, number, base, input ready);
    modport sink   (input valid, number, base, output ready);
endinterface

interface itoa_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       last;
    logic       bad_base;

    modport source (output valid, character, last, bad_base, input ready);
    modport sink   (input valid, character, last, bad_base, output ready);
endinterface

`default_nettype wire

@@ rtl/itoa_front.sv @@
// Front end: accepts input transactions, checks the radix, forms the magnitude.
`default_nettype none

module itoa_front (
    input  wire logic         clk,
    input  wire logic         rst_n,
    itoa_in_if.sink           in_ch,
    output itoa_pkg::job_t    push_job,
    output logic              push_valid,
    input  wire logic         push_ready
);
    import itoa_pkg::*;

    logic  fvalid_reg, fvalid_next;
    job_t  fjob_reg, fjob_next;
    logic  accept;
    logic  [NUM_W-1:0] pattern;

    assign in_ch.ready = !fvalid_reg || push_ready;
    assign accept      = in_ch.valid && in_ch.ready;
    assign pattern     = $unsigned(in_ch.number);

    always_comb
    begin
        fjob_next          = fjob_reg;
        fvalid_next        = fvalid_reg && !push_ready;
        if (accept)
        begin
            fvalid_next        = 1'b1;
            fjob_next.bad      = (in_ch.base < BASE_MIN) || (in_ch.base > BASE_MAX);
            fjob_next.negative = (in_ch.base == BASE_DEC) && pattern[NUM_W-1];
            fjob_next.radix    = in_ch.base;
            fjob_next.mag      = fjob_next.negative ? (NUM_W'(0) - pattern) : pattern;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fvalid_reg <= 1'b0;
        else
            fvalid_reg <= fvalid_next;
    end

    always_ff @(posedge clk)
    begin
        fjob_reg <= fjob_next;
    end

    assign push_valid = fvalid_reg;
    assign push_job   = fjob_reg;

endmodule

`default_nettype wire

@@ rtl/itoa_queue.sv @@
// Short job queue between front and back.
`default_nettype none

module itoa_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire itoa_pkg::job_t  push_job,
    input  wire logic            push_valid,
    output logic                 push_ready,
    output itoa_pkg::job_t       pop_job,
    output logic                 pop_valid,
    input  wire logic            pop_ready
);
    import itoa_pkg::*;

    job_t               entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;
    logic               do_push, do_pop;

    assign push_ready = (count_reg != Q_CNT_W'(Q_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_job    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule

`default_nettype wire

@@ rtl/itoa_back.sv @@
// Back end: byte-wise division by the radix, digit stack, character output.
`default_nettype none

module itoa_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire itoa_pkg::job_t  pop_job,
    input  wire logic            pop_valid,
    output logic                 pop_ready,
    itoa_out_if.source           out_ch
);
    import itoa_pkg::*;

    back_state_t        state_reg, state_next;
    logic [NUM_W-1:0]   mag_reg, mag_next;
    logic [NUM_W-1:0]   quo_reg, quo_next;
    logic [BASE_W-1:0]  rem_reg, rem_next;
    logic [CHUNK_W-1:0] chunk_reg, chunk_next;
    logic [BASE_W-1:0]  radix_reg, radix_next;
    logic               neg_reg, neg_next;
    logic [IDX_W-1:0]   ndig_reg, ndig_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [CHAR_W-1:0]  stack_reg [DIGIT_MAX];

    logic               out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]  char_reg, char_next;
    logic               last_reg, last_next;
    logic               bad_reg, bad_next;

    logic               can_load;
    logic               push_en;
    logic [CHAR_W-1:0]  push_char;

    // one byte of restoring division per cycle
    logic [BYTE_W-1:0]  cur_byte;
    logic [BYTE_W-1:0]  q_byte;
    logic [BASE_W:0]    trial;
    logic [BASE_W-1:0]  step_rem;
    logic [NUM_W-1:0]   quo_with;
    logic               div_last;

    assign can_load = !out_valid_reg || out_ch.ready;
    assign cur_byte = mag_reg[chunk_reg*BYTE_W +: BYTE_W];
    assign div_last = (chunk_reg == '0);

    always_comb
    begin
        step_rem = rem_reg;
        q_byte   = '0;
        trial    = '0;
        for (int i = BYTE_W - 1; i >= 0; i--)
        begin
            trial = {step_rem, cur_byte[i]};
            if (trial >= {1'b0, radix_reg})
            begin
                trial     = trial - {1'b0, radix_reg};
                q_byte[i] = 1'b1;
            end
            step_rem = trial[BASE_W-1:0];
        end
        quo_with = quo_reg;
        quo_with[chunk_reg*BYTE_W +: BYTE_W] = q_byte;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (pop_valid)
                    state_next = pop_job.bad ? ST_ERR : ST_DIV;
            ST_DIV:
                if (div_last && (quo_with == '0))
                    state_next = neg_reg ? ST_SIGN : ST_DIGITS;
            ST_SIGN:
                if (can_load)
                    state_next = ST_DIGITS;
            ST_DIGITS:
                if (can_load && (rd_idx_reg == '0))
                    state_next = ST_IDLE;
            ST_ERR:
                if (can_load)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        mag_next       = mag_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        chunk_next     = chunk_reg;
        radix_next     = radix_reg;
        neg_next       = neg_reg;
        ndig_next      = ndig_reg;
        rd_idx_next    = rd_idx_reg;
        push_en        = 1'b0;
        push_char      = digit_char(step_rem);
        pop_ready      = 1'b0;
        out_valid_next = out_valid_reg && !out_ch.ready;
        char_next      = char_reg;
        last_next      = last_reg;
        bad_next       = bad_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                pop_ready = 1'b1;
                if (pop_valid)
                begin
                    mag_next   = pop_job.mag;
                    radix_next = pop_job.radix;
                    neg_next   = pop_job.negative;
                    quo_next   = '0;
                    rem_next   = '0;
                    chunk_next = top_byte(pop_job.mag);
                    ndig_next  = '0;
                end
            end
            ST_DIV:
            begin
                rem_next   = step_rem;
                quo_next   = quo_with;
                chunk_next = chunk_reg - 1'b1;
                if (div_last)
                begin
                    push_en     = 1'b1;
                    ndig_next   = ndig_reg + 1'b1;
                    rd_idx_next = ndig_reg;
                    mag_next    = quo_with;
                    quo_next    = '0;
                    rem_next    = '0;
                    chunk_next  = top_byte(quo_with);
                end
            end
            ST_SIGN:
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    char_next      = CHAR_MINUS;
                    last_next      = 1'b0;
                    bad_next       = 1'b0;
                end
            ST_DIGITS:
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    char_next      = stack_reg[rd_idx_reg];
                    last_next      = (rd_idx_reg == '0);
                    bad_next       = 1'b0;
                    if (rd_idx_reg != '0)
                        rd_idx_next = rd_idx_reg - 1'b1;
                end
            ST_ERR:
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    char_next      = CHAR_NUL;
                    last_next      = 1'b1;
                    bad_next       = 1'b1;
                end
            default:
            begin
                pop_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg    <= mag_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        chunk_reg  <= chunk_next;
        radix_reg  <= radix_next;
        neg_reg    <= neg_next;
        ndig_reg   <= ndig_next;
        rd_idx_reg <= rd_idx_next;
        char_reg   <= char_next;
        last_reg   <= last_next;
        bad_reg    <= bad_next;
        if (push_en)
            stack_reg[ndig_reg] <= push_char;
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.character = char_reg;
    assign out_ch.last      = last_reg;
    assign out_ch.bad_base  = bad_reg;

endmodule

`default_nettype wire

@@ rtl/integer_to_radix_ascii.sv @@
// Top level of the integer to radix ASCII text converter.
//
// Usage:
//   in_ch  : one transaction carries a signed 32-bit number and a 6-bit radix.
//   out_ch : the text comes back one ASCII character per transaction, most
//            significant digit first, last = 1 on the final character.
//            Radix 10 with a negative number gets a leading '-'; any other
//            radix converts the raw 32-bit pattern. A radix outside 2..36
//            gives one transaction with character 0, last = 1, bad_base = 1.
//   Flow: the job is held in the front register, then in the queue, then
//   each digit takes one restoring division step per byte of the remaining
//   quotient (from its top nonzero byte); then one character per cycle while
//   the receiver is ready. The divider is the limit; one number is converted
//   at a time, the queue holds two more.
//   Reset (rst_n low, asynchronous) empties the front register and queue,
//   returns the back end to idle and drops any pending output.
//   A stalled receiver holds the output register; the back end waits, the
//   queue fills and then in_ch.ready drops.
`default_nettype none

module integer_to_radix_ascii (
    input  wire logic  clk,
    input  wire logic  rst_n,
    itoa_in_if.sink    in_ch,
    itoa_out_if.source out_ch
);
    import itoa_pkg::*;

    job_t push_job, pop_job;
    logic push_valid, push_ready;
    logic pop_valid, pop_ready;

    // classify radix and sign, register the job
    itoa_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .push_job   (push_job),
        .push_valid (push_valid),
        .push_ready (push_ready)
    );

    // decouples acceptance from conversion
    itoa_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_job   (push_job),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .pop_job    (pop_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready)
    );

    // divide, stack digits, emit in reverse
    itoa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_job   (pop_job),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .out_ch    (out_ch)
    );

endmodule

`default_nettype wire

@@ rtl/itoa_checker.sv @@
// Port-level assertions for the converter, bound to the top level.
`default_nettype none

module itoa_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_character,
    input wire logic       out_last,
    input wire logic       out_bad_base
);
    import itoa_pkg::*;

    // stalled output transaction holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_character)
            && $stable(out_last) && $stable(out_bad_base))
        else $error("output changed while stalled");

    // error transaction is a single NUL marked last
    a_bad_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_bad_base |-> (out_character == CHAR_NUL) && out_last)
        else $error("bad radix transaction malformed");

    // normal text uses only minus, 0-9 and A-Z
    a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_bad_base |->
            ((out_character >= CHAR_ZERO) && (out_character <= CHAR_NINE))
            || ((out_character >= CHAR_A) && (out_character <= CHAR_Z))
            || (out_character == CHAR_MINUS))
        else $error("character outside digit set");

    // a minus sign is never marked last
    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_character == CHAR_MINUS) |-> !out_last)
        else $error("minus sign marked last");

endmodule

bind integer_to_radix_ascii itoa_checker u_itoa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_character (out_ch.character),
    .out_last      (out_ch.last),
    .out_bad_base  (out_ch.bad_base)
);

`default_nettype wire
